// ===== hw/rtl/fld_pkg.sv =====
// Shared types and codes for the framebuffer line draw engine.
// No dependencies; the datapath, the controller and the top import it.
`timescale 1ns / 1ps
package fld_pkg;

  localparam logic [1:0] KIND_SET   = 2'd0;
  localparam logic [1:0] KIND_GET   = 2'd1;
  localparam logic [1:0] KIND_LINE  = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  localparam logic [8:0] FRAME_RESET = 9'd256;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_PIX_WR,
    DP_PIX_RD,
    DP_DIV_GO,
    DP_MUL_ICPT,
    DP_MUL_START,
    DP_ACC_INIT,
    DP_WALK,
    DP_SWEEP_ZERO,
    DP_SWEEP_ONES
  } dp_op_t;

  typedef struct packed {
    logic   load;
    logic   res_en;
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic zero_len;
    logic div_done;
    logic walk_last;
    logic sweep_last;
  } status_t;

endpackage

// ===== hw/rtl/fld_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
module fld_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/fld_div.sv =====
// Iterative restoring divider for the line slope, one quotient bit per cycle.
// No dependencies; used by the datapath.
`timescale 1ns / 1ps
module fld_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        running;
  logic [4:0]  cnt;
  logic [15:0] rem;
  logic [15:0] dvs;
  logic [16:0] trial;
  logic [16:0] diff;
  logic        qbit;

  assign trial = {rem, quotient[31]};
  assign diff  = trial - {1'b0, dvs};
  assign qbit  = !diff[16];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (running) begin
      rem      <= qbit ? diff[15:0] : trial[15:0];
      quotient <= {quotient[30:0], qbit};
    end
  end

endmodule

// ===== hw/rtl/fld_datapath.sv =====
// Datapath: frame registers, line geometry, slope and stepping accumulator,
// pixel addressing and the pixel store. Depends on fld_pkg, fld_div, fld_ram.
`timescale 1ns / 1ps
module fld_datapath #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int COLOR_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  fld_pkg::cmd_t      cmd,
  output fld_pkg::status_t   status,
  input  logic [1:0]         kind,
  input  logic signed [15:0] x0,
  input  logic signed [15:0] y0,
  input  logic signed [15:0] x1,
  input  logic signed [15:0] y1,
  input  logic [31:0]        pixel_color,
  input  logic               cfg_valid,
  input  logic               cfg_index,
  input  logic [8:0]         cfg_data,
  output logic               in_range,
  output logic [31:0]        read_color
);
  import fld_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

  logic [8:0]  frame_width;
  logic [8:0]  frame_height;
  logic [12:0] uw;
  logic [12:0] uh;

  logic [1:0]            kind_q;
  logic signed [15:0]    px0;
  logic signed [15:0]    py0;
  logic [COLOR_BITS-1:0] color_q;

  logic               steep;
  logic               neg;
  logic signed [15:0] maj0;
  logic signed [15:0] min0;
  logic signed [15:0] lo;
  logic signed [15:0] hi;
  logic [15:0]        amin;
  logic [15:0]        amaj;
  logic               zero_len;

  logic signed [17:0] slope;
  logic signed [39:0] prod;
  logic signed [39:0] icpt;
  logic signed [39:0] acc;
  logic signed [15:0] s;
  logic [AW-1:0]      sweep_cnt;

  // Geometry of the incoming line.
  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic [16:0]        adx;
  logic [16:0]        ady;
  logic               steep_in;
  logic signed [15:0] maj0_in;
  logic signed [15:0] maj1_in;

  logic               div_done;
  logic [31:0]        quo;
  logic signed [17:0] quo_s;
  logic signed [17:0] mul_a;
  logic signed [35:0] prod_w;

  logic signed [39:0] acc_adj;
  logic signed [23:0] m;
  logic signed [23:0] s_ext;
  logic signed [23:0] wx;
  logic signed [23:0] wy;
  logic signed [23:0] p0x;
  logic signed [23:0] p0y;
  logic               inside0;
  logic               inside_w;
  logic [AW-1:0]      addr0;
  logic [AW-1:0]      addr_w;

  logic                  we;
  logic [AW-1:0]         waddr;
  logic [COLOR_BITS-1:0] wdata;
  logic                  re;
  logic [COLOR_BITS-1:0] rdata;

  function automatic logic inside_f(input logic signed [23:0] px,
                                    input logic signed [23:0] py,
                                    input logic [12:0] w, input logic [12:0] h);
    return !px[23] && (px[22:0] < 23'(w)) && !py[23] && (py[22:0] < 23'(h));
  endfunction

  function automatic logic [AW-1:0] addr_f(input logic signed [23:0] px,
                                           input logic signed [23:0] py);
    return AW'(32'(py[11:0]) * 32'(MAX_WIDTH) + 32'(px[11:0]));
  endfunction

  assign uw = (13'(frame_width) < 13'(MAX_WIDTH)) ? 13'(frame_width) : 13'(MAX_WIDTH);
  assign uh = (13'(frame_height) < 13'(MAX_HEIGHT)) ? 13'(frame_height) : 13'(MAX_HEIGHT);

  assign dx       = {x1[15], x1} - {x0[15], x0};
  assign dy       = {y1[15], y1} - {y0[15], y0};
  assign adx      = dx[16] ? -dx : dx;
  assign ady      = dy[16] ? -dy : dy;
  assign steep_in = ady > adx;
  assign maj0_in  = steep_in ? y0 : x0;
  assign maj1_in  = steep_in ? y1 : x1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_RESET;
      frame_height <= FRAME_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_WIDTH) begin
        frame_width <= cfg_data;
      end else begin
        frame_height <= cfg_data;
      end
    end
  end

  fld_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.op == DP_DIV_GO),
    .dividend ({amin, 16'h0000}),
    .divisor  (amaj),
    .done     (div_done),
    .quotient (quo)
  );

  assign quo_s  = $signed({1'b0, quo[16:0]});
  assign mul_a  = (cmd.op == DP_MUL_ICPT) ? 18'(maj0) : 18'(lo);
  assign prod_w = mul_a * slope;

  // Truncate toward zero as the divide by 2^16 does; the rounding half is added at accumulator start.
  assign acc_adj = acc + (acc[39] ? 40'sd65535 : 40'sd0);
  assign m       = acc_adj[39:16];
  assign s_ext   = 24'(s);
  assign wx      = steep ? m : s_ext;
  assign wy      = steep ? s_ext : m;
  assign p0x     = 24'(px0);
  assign p0y     = 24'(py0);
  assign inside0  = inside_f(p0x, p0y, uw, uh);
  assign inside_w = inside_f(wx, wy, uw, uh);
  assign addr0    = addr_f(p0x, p0y);
  assign addr_w   = addr_f(wx, wy);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q   <= kind;
      px0      <= x0;
      py0      <= y0;
      color_q  <= COLOR_BITS'(pixel_color);
      steep    <= steep_in;
      neg      <= steep_in ? (dy[16] ^ dx[16]) : (dx[16] ^ dy[16]);
      maj0     <= maj0_in;
      min0     <= steep_in ? x0 : y0;
      lo       <= (maj0_in < maj1_in) ? maj0_in : maj1_in;
      hi       <= (maj0_in < maj1_in) ? maj1_in : maj0_in;
      amin     <= steep_in ? adx[15:0] : ady[15:0];
      amaj     <= steep_in ? ady[15:0] : adx[15:0];
      zero_len <= (dx == 17'sd0) && (dy == 17'sd0);
    end
    if (div_done) begin
      slope <= neg ? -quo_s : quo_s;
    end
    case (cmd.op)
      DP_MUL_ICPT: prod <= 40'(prod_w);
      DP_MUL_START: begin
        icpt <= $signed({{8{min0[15]}}, min0, 16'h0000}) - prod;
        prod <= 40'(prod_w);
      end
      DP_ACC_INIT: begin
        acc <= prod + icpt + 40'sd32768;
        s   <= lo;
      end
      DP_WALK: begin
        acc <= acc + 40'(slope);
        s   <= s + 16'sd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
    end else if (cmd.op == DP_SWEEP_ZERO || cmd.op == DP_SWEEP_ONES) begin
      sweep_cnt <= status.sweep_last ? '0 : sweep_cnt + AW'(1);
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = addr0;
    wdata = color_q;
    case (cmd.op)
      DP_PIX_WR: we = inside0;
      DP_WALK: begin
        we    = inside_w;
        waddr = addr_w;
      end
      DP_SWEEP_ZERO: begin
        we    = 1'b1;
        waddr = sweep_cnt;
        wdata = '0;
      end
      DP_SWEEP_ONES: begin
        we    = 1'b1;
        waddr = sweep_cnt;
        wdata = '1;
      end
      default: ;
    endcase
  end

  assign re = (cmd.op == DP_PIX_RD);

  fld_ram #(
    .WIDTH (COLOR_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (addr0),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.res_en) begin
      case (kind_q)
        KIND_SET: begin
          in_range   <= inside0;
          read_color <= '0;
        end
        KIND_GET: begin
          in_range   <= inside0;
          read_color <= inside0 ? 32'(rdata) : 32'd0;
        end
        default: begin
          in_range   <= 1'b1;
          read_color <= '0;
        end
      endcase
    end
  end

  assign status.zero_len   = zero_len;
  assign status.div_done   = div_done;
  assign status.walk_last  = (s + 16'sd1) == hi;
  assign status.sweep_last = sweep_cnt == AW'(DEPTH - 1);

endmodule

// ===== hw/rtl/fld_ctrl.sv =====
// Controller state machine: sequences each command through the datapath.
// Depends on fld_pkg.
`timescale 1ns / 1ps
module fld_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [1:0]       kind,
  input  fld_pkg::status_t status,
  output fld_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             done
);
  import fld_pkg::*;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_SET,
    S_GET_RD,
    S_GET_CAP,
    S_DIV_GO,
    S_DIV_WAIT,
    S_ICPT,
    S_START,
    S_ACC,
    S_WALK,
    S_CLEAR
  } state_t;

  state_t state;
  state_t state_next;
  logic   finish;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '{load: 1'b0, res_en: 1'b0, op: DP_NOP};
    state_next = state;
    finish     = 1'b0;
    unique case (state)
      S_INIT: begin
        cmd.op = DP_SWEEP_ZERO;
        if (status.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          unique case (kind)
            KIND_SET:  state_next = S_SET;
            KIND_GET:  state_next = S_GET_RD;
            KIND_LINE: state_next = S_DIV_GO;
            default:   state_next = S_CLEAR;
          endcase
        end
      end
      S_SET: begin
        cmd.op = DP_PIX_WR;
        finish = 1'b1;
      end
      S_GET_RD: begin
        cmd.op     = DP_PIX_RD;
        state_next = S_GET_CAP;
      end
      S_GET_CAP: finish = 1'b1;
      S_DIV_GO: begin
        if (status.zero_len) begin
          finish = 1'b1;
        end else begin
          cmd.op     = DP_DIV_GO;
          state_next = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (status.div_done) begin
          state_next = S_ICPT;
        end
      end
      S_ICPT: begin
        cmd.op     = DP_MUL_ICPT;
        state_next = S_START;
      end
      S_START: begin
        cmd.op     = DP_MUL_START;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.op     = DP_ACC_INIT;
        state_next = S_WALK;
      end
      S_WALK: begin
        cmd.op = DP_WALK;
        finish = status.walk_last;
      end
      S_CLEAR: begin
        cmd.op = DP_SWEEP_ONES;
        finish = status.sweep_last;
      end
      default: state_next = S_IDLE;
    endcase
    if (finish) begin
      cmd.res_en = 1'b1;
      state_next = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish;
    end
  end

endmodule

// ===== hw/rtl/framebuffer_line_draw_engine_top.sv =====
// A line runs the slope divider, then the walk writes one pixel per cycle along
// its major axis; a zero-length line finishes without dividing.
// One command at a time; busy is low again in the cycle of the done strobe.
// After reset the store is swept to zero, one entry per cycle, with busy high;
// the receiver cannot stall.
`timescale 1ns / 1ps
module framebuffer_line_draw_engine_top #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int COLOR_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind,
  input  logic signed [15:0] x0,
  input  logic signed [15:0] y0,
  input  logic signed [15:0] x1,
  input  logic signed [15:0] y1,
  input  logic [31:0]        pixel_color,
  output logic               done,
  output logic               in_range,
  output logic [31:0]        read_color,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [8:0]         cfg_data
);
  import fld_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Frame registers take a write only while no command is in flight.
  assign cfg_ready = !busy;

  fld_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .kind   (kind),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  fld_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .COLOR_BITS (COLOR_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .kind        (kind),
    .x0          (x0),
    .y0          (y0),
    .x1          (x1),
    .y1          (y1),
    .pixel_color (pixel_color),
    .cfg_valid   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_range    (in_range),
    .read_color  (read_color)
  );

endmodule

// ===== hw/rtl/fld_checker.sv =====
// Port-level checks for the framebuffer line draw engine, bound to the top.
// Depends on framebuffer_line_draw_engine_top.
`timescale 1ns / 1ps
module fld_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        in_range,
  input logic [31:0] read_color
);

  // Reset starts the clearing sweep, so no transfer is taken right after it.
  a_reset_busy: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done strobe lasted more than one cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done strobe while busy");

  a_out_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !in_range) |-> (read_color == 32'd0))
    else $error("read_color nonzero for out-of-range result");

endmodule

bind framebuffer_line_draw_engine_top fld_checker u_fld_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .in_range   (in_range),
  .read_color (read_color)
);
